[src/tae_pkg.sv]
// ----------------------------------------------------------------------------
// Tilt angle estimator package
// Widths, constants, sequencer states, control structs and the arctangent
// table shared by the estimator modules.
// ----------------------------------------------------------------------------
package tae_pkg;

  localparam int unsigned InW      = 16;
  localparam int unsigned OutW     = 16;
  localparam int unsigned RadiusW  = 16;
  localparam int unsigned RateHzW  = 13;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned MulAW    = 40;
  localparam int unsigned MulBW    = 22;
  localparam int unsigned ProdW    = MulAW + MulBW;
  localparam int unsigned RateW    = 21;
  localparam int unsigned DiffW    = RateW + 1;
  localparam int unsigned VecW     = 36;
  localparam int unsigned AngW     = 26;
  localparam int unsigned AtanW    = 22;
  localparam int unsigned ResW     = AngW - 9;
  localparam int unsigned StepW    = 5;
  localparam int unsigned TableLen = 24;

  localparam logic signed [MulAW-1:0] RateK   = 40'sd1171271;
  localparam logic signed [MulAW-1:0] AccelK  = 40'sd5141509;
  localparam logic signed [ProdW-1:0] Half16  = 62'sd32768;
  localparam logic signed [ProdW-1:0] Half32  = 62'sd2147483648;
  localparam logic signed [AngW-1:0]  Quarter = 26'sd5898240;
  localparam logic signed [AngW-1:0]  AngHalf = 26'sd256;
  localparam logic signed [ResW-1:0]  AngleLimit = 17'sd23040;
  localparam logic signed [ResW-1:0]  AngleFloor = -17'sd23040;

  typedef enum logic {
    RegRadius = 1'b0,
    RegRateHz = 1'b1
  } tae_reg_e;

  typedef enum logic [3:0] {
    StIdle,
    StRate,
    StAccY,
    StRateSq,
    StCentr,
    StAccX,
    StDiff,
    StTang,
    StPrep,
    StNorm,
    StRot,
    StCordic,
    StFinish
  } tae_state_e;

  typedef struct packed {
    tae_state_e       state;
    logic [StepW-1:0] step;
    logic             take;
    logic             done;
  } tae_ctrl_t;

  typedef struct packed {
    logic zero;
    logic norm_done;
  } tae_stat_t;

  // atan(2^-i) in degrees * 65536, rounded.
  function automatic logic [AtanW-1:0] atan_q16(input logic [StepW-1:0] idx);
    logic [AtanW-1:0] val;
    unique case (idx)
      5'd0:    val = 22'd2949120;
      5'd1:    val = 22'd1740967;
      5'd2:    val = 22'd919879;
      5'd3:    val = 22'd466945;
      5'd4:    val = 22'd234379;
      5'd5:    val = 22'd117304;
      5'd6:    val = 22'd58666;
      5'd7:    val = 22'd29335;
      5'd8:    val = 22'd14668;
      5'd9:    val = 22'd7334;
      5'd10:   val = 22'd3667;
      5'd11:   val = 22'd1833;
      5'd12:   val = 22'd917;
      5'd13:   val = 22'd458;
      5'd14:   val = 22'd229;
      5'd15:   val = 22'd115;
      5'd16:   val = 22'd57;
      5'd17:   val = 22'd29;
      5'd18:   val = 22'd14;
      5'd19:   val = 22'd7;
      5'd20:   val = 22'd4;
      5'd21:   val = 22'd2;
      5'd22:   val = 22'd1;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

[src/tilt_angle_estimator.sv]
// ----------------------------------------------------------------------------
// Tilt angle estimator
// Converts one inertial sample to a tilt angle in degrees * 128, correcting
// for centripetal and tangential acceleration, using a CORDIC vectoring pass.
// ----------------------------------------------------------------------------
//   Channel  | Signals                                        | Direction
//   ---------+------------------------------------------------+----------
//   sample   | in_valid_i/in_ready_o, accel_x/y_i, gyro_z_i   | in
//   angle    | out_valid_o/out_ready_i, angle_deg/valid_o     | out
//   config   | cfg_we_i, cfg_idx_i, cfg_wdata_i               | in
//
// After a transfer, a sample passes through the multiply phase, normalization
// and the CORDIC steps (both skipped for a zero vector) before the next ready.
// The single shared multiplier runs seven products, then the shift unit
// normalizes and runs one CORDIC step per cycle.
// The result sits in an output register, so a new sample is taken while it
// waits; the sequencer stalls at its last step only if that register is full.
// Reset restores the register defaults and clears the stored previous rate.
// ----------------------------------------------------------------------------
module tilt_angle_estimator import tae_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [CfgW-1:0]        cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [InW-1:0]  accel_x_i,
  input  logic signed [InW-1:0]  accel_y_i,
  input  logic signed [InW-1:0]  gyro_z_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [OutW-1:0] angle_deg_o,
  output logic                   angle_valid_o
);

  localparam int unsigned NumSteps = (CORDIC_STEPS > TableLen) ? TableLen : CORDIC_STEPS;

  logic [RadiusW-1:0]     radius_q, radius_d;
  logic [RateHzW-1:0]     rate_hz_q, rate_hz_d;
  logic                   out_valid_q, out_valid_d;
  logic signed [OutW-1:0] angle_q, angle_d;
  logic                   aval_q, aval_d;
  logic                   out_free;
  tae_ctrl_t              ctrl;
  tae_stat_t              stat;
  logic signed [OutW-1:0] dp_angle;
  logic                   dp_valid;

  assign out_free = !out_valid_q || out_ready_i;

  tae_ctrl #(
    .NumSteps(NumSteps)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl)
  );

  tae_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .accel_x_i (accel_x_i),
    .accel_y_i (accel_y_i),
    .gyro_z_i  (gyro_z_i),
    .radius_i  (radius_q),
    .rate_hz_i (rate_hz_q),
    .stat_o    (stat),
    .angle_o   (dp_angle),
    .valid_o   (dp_valid)
  );

  always_comb begin
    radius_d  = radius_q;
    rate_hz_d = rate_hz_q;
    if (cfg_we_i) begin
      unique case (tae_reg_e'(cfg_idx_i))
        RegRadius: radius_d  = cfg_wdata_i[RadiusW-1:0];
        RegRateHz: rate_hz_d = cfg_wdata_i[RateHzW-1:0];
        default:   radius_d  = radius_q;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    angle_d     = angle_q;
    aval_d      = aval_q;
    if (ctrl.done) begin
      out_valid_d = 1'b1;
      angle_d     = dp_angle;
      aval_d      = dp_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q    <= 16'd9830;
      rate_hz_q   <= 13'd38;
      out_valid_q <= 1'b0;
    end else begin
      radius_q    <= radius_d;
      rate_hz_q   <= rate_hz_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q <= angle_d;
    aval_q  <= aval_d;
  end

  assign out_valid_o   = out_valid_q;
  assign angle_deg_o   = angle_q;
  assign angle_valid_o = aval_q;

endmodule

[src/tae_ctrl.sv]
// ----------------------------------------------------------------------------
// Tilt angle estimator sequencer
// Steps one sample through the multiply, normalize, CORDIC and finish phases.
// ----------------------------------------------------------------------------
module tae_ctrl import tae_pkg::*; #(
  parameter int unsigned NumSteps = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      out_free_i,
  input  tae_stat_t stat_i,
  output logic      in_ready_o,
  output tae_ctrl_t ctrl_o
);

  localparam logic [StepW-1:0] LastStep = StepW'(NumSteps - 1);

  tae_state_e       state_q, state_d;
  logic [StepW-1:0] step_q, step_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (in_valid_i) state_d = StRate;
      StRate:   state_d = StAccY;
      StAccY:   state_d = StRateSq;
      StRateSq: state_d = StCentr;
      StCentr:  state_d = StAccX;
      StAccX:   state_d = StDiff;
      StDiff:   state_d = StTang;
      StTang:   state_d = StPrep;
      StPrep:   state_d = stat_i.zero ? StFinish : StNorm;
      StNorm:   if (stat_i.norm_done) state_d = StRot;
      StRot:    state_d = StCordic;
      StCordic: if (step_q == LastStep) state_d = StFinish;
      StFinish: if (out_free_i) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    step_d = step_q;
    if (state_q == StRot) begin
      step_d = '0;
    end else if (state_q == StCordic) begin
      step_d = step_q + StepW'(1);
    end
  end

  always_comb begin
    in_ready_o   = (state_q == StIdle);
    ctrl_o.state = state_q;
    ctrl_o.step  = step_q;
    ctrl_o.take  = (state_q == StIdle) && in_valid_i;
    ctrl_o.done  = (state_q == StFinish) && out_free_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

[src/tae_datapath.sv]
// ----------------------------------------------------------------------------
// Tilt angle estimator datapath
// Shared multiplier for unit conversion and motion correction, normalizer,
// CORDIC vectoring unit and result rounding.
// ----------------------------------------------------------------------------
module tae_datapath import tae_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tae_ctrl_t                ctrl_i,
  input  logic signed [InW-1:0]    accel_x_i,
  input  logic signed [InW-1:0]    accel_y_i,
  input  logic signed [InW-1:0]    gyro_z_i,
  input  logic [RadiusW-1:0]       radius_i,
  input  logic [RateHzW-1:0]       rate_hz_i,
  output tae_stat_t                stat_o,
  output logic signed [OutW-1:0]   angle_o,
  output logic                     valid_o
);

  logic signed [InW-1:0]   ax_q, ax_d, ay_q, ay_d, gz_q, gz_d;
  logic signed [RateW-1:0] w_q, w_d, prev_q, prev_d;
  logic signed [DiffW-1:0] dw_q, dw_d;
  logic signed [MulAW-1:0] tmp_q, tmp_d;
  logic signed [VecW-1:0]  cx_q, cx_d, cy_q, cy_d, x_q, x_d, y_q, y_d;
  logic [VecW-1:0]         m_q, m_d;
  logic signed [AngW-1:0]  acc_q, acc_d;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod, sum16, sum32, rnd16, rnd32;
  logic [VecW-1:0]         abs_cx, abs_cy;
  logic signed [VecW-1:0]  dx, dy;
  logic [AngW-1:0]         atan_ext;
  logic signed [AngW-1:0]  acc_sum;
  logic signed [ResW-1:0]  res_raw, res_clip, res_fin;
  logic                    cx_pos, cx_neg;

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl_i.state)
      StRate: begin
        mul_a = RateK;
        mul_b = {{(MulBW-InW){gz_q[InW-1]}}, gz_q};
      end
      StAccY: begin
        mul_a = AccelK;
        mul_b = {{(MulBW-InW){ay_q[InW-1]}}, ay_q};
      end
      StRateSq: begin
        mul_a = {{(MulAW-RateW){w_q[RateW-1]}}, w_q};
        mul_b = {{(MulBW-RateW){w_q[RateW-1]}}, w_q};
      end
      StCentr, StTang: begin
        mul_a = tmp_q;
        mul_b = {{(MulBW-RadiusW){1'b0}}, radius_i};
      end
      StAccX: begin
        mul_a = AccelK;
        mul_b = {{(MulBW-InW){ax_q[InW-1]}}, ax_q};
      end
      StDiff: begin
        mul_a = {{(MulAW-DiffW){dw_q[DiffW-1]}}, dw_q};
        mul_b = {{(MulBW-RateHzW){1'b0}}, rate_hz_i};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod  = ProdW'(mul_a) * ProdW'(mul_b);
  assign sum16 = prod + Half16;
  assign sum32 = prod + Half32;
  assign rnd16 = sum16 >>> 16;
  assign rnd32 = sum32 >>> 32;

  assign abs_cx   = cx_q[VecW-1] ? VecW'(-cx_q) : VecW'(cx_q);
  assign abs_cy   = cy_q[VecW-1] ? VecW'(-cy_q) : VecW'(cy_q);
  assign dx       = y_q >>> ctrl_i.step;
  assign dy       = x_q >>> ctrl_i.step;
  assign atan_ext = {{(AngW-AtanW){1'b0}}, atan_q16(ctrl_i.step)};

  assign stat_o.zero      = (cx_q == '0) && (cy_q == '0);
  assign stat_o.norm_done = (m_q[VecW-1:31] == '0) && m_q[30];

  always_comb begin
    ax_d   = ax_q;
    ay_d   = ay_q;
    gz_d   = gz_q;
    w_d    = w_q;
    prev_d = prev_q;
    dw_d   = dw_q;
    tmp_d  = tmp_q;
    cx_d   = cx_q;
    cy_d   = cy_q;
    x_d    = x_q;
    y_d    = y_q;
    m_d    = m_q;
    acc_d  = acc_q;
    if (ctrl_i.take) begin
      ax_d = accel_x_i;
      ay_d = accel_y_i;
      gz_d = gyro_z_i;
    end
    unique case (ctrl_i.state)
      StRate:   w_d = rnd16[RateW-1:0];
      StAccY: begin
        cy_d   = rnd16[VecW-1:0];
        dw_d   = {w_q[RateW-1], w_q} - {prev_q[RateW-1], prev_q};
        prev_d = w_q;
      end
      StRateSq: tmp_d = prod[MulAW-1:0];
      StCentr:  cy_d = cy_q + rnd32[VecW-1:0];
      StAccX:   cx_d = rnd16[VecW-1:0];
      StDiff:   tmp_d = prod[MulAW-1:0];
      StTang:   cx_d = cx_q + rnd16[VecW-1:0];
      StPrep: begin
        x_d = cy_q;
        y_d = -cx_q;
        m_d = (abs_cy > abs_cx) ? abs_cy : abs_cx;
      end
      StNorm: begin
        if (!stat_o.norm_done) begin
          if (m_q[VecW-1:31] != '0) begin
            x_d = x_q >>> 1;
            y_d = y_q >>> 1;
            m_d = m_q >> 1;
          end else if (m_q[VecW-1:26] == '0) begin
            x_d = x_q <<< 4;
            y_d = y_q <<< 4;
            m_d = m_q << 4;
          end else begin
            x_d = x_q <<< 1;
            y_d = y_q <<< 1;
            m_d = m_q << 1;
          end
        end
      end
      StRot: begin
        acc_d = '0;
        if (x_q[VecW-1]) begin
          if (!y_q[VecW-1]) begin
            x_d   = y_q;
            y_d   = -x_q;
            acc_d = Quarter;
          end else begin
            x_d   = -y_q;
            y_d   = x_q;
            acc_d = -Quarter;
          end
        end
      end
      StCordic: begin
        if (!y_q[VecW-1]) begin
          x_d   = x_q + dx;
          y_d   = y_q - dy;
          acc_d = acc_q + atan_ext;
        end else begin
          x_d   = x_q - dx;
          y_d   = y_q + dy;
          acc_d = acc_q - atan_ext;
        end
      end
      default: begin
        acc_d = acc_q;
      end
    endcase
  end

  // Round to degrees * 128, clamp, then apply the sign guard.
  always_comb begin
    acc_sum = acc_q + AngHalf;
    res_raw = acc_sum[AngW-1:9];
    cx_pos  = !cx_q[VecW-1] && (cx_q != '0);
    cx_neg  = cx_q[VecW-1];
    if (res_raw > AngleLimit) begin
      res_clip = AngleLimit;
    end else if (res_raw < AngleFloor) begin
      res_clip = AngleFloor;
    end else begin
      res_clip = res_raw;
    end
    res_fin = res_clip;
    if ((cx_pos && (res_clip > 0)) || (cx_neg && (res_clip < 0)) || stat_o.zero) begin
      res_fin = '0;
    end
    angle_o = res_fin[OutW-1:0];
    valid_o = !stat_o.zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else begin
      prev_q <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q  <= ax_d;
    ay_q  <= ay_d;
    gz_q  <= gz_d;
    w_q   <= w_d;
    dw_q  <= dw_d;
    tmp_q <= tmp_d;
    cx_q  <= cx_d;
    cy_q  <= cy_d;
    x_q   <= x_d;
    y_q   <= y_d;
    m_q   <= m_d;
    acc_q <= acc_d;
  end

endmodule

[src/tae_checker.sv]
// ----------------------------------------------------------------------------
// Tilt angle estimator checker
// Port-level checks on range, invalid results, busy window and output stalls.
// ----------------------------------------------------------------------------
module tae_checker import tae_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic signed [OutW-1:0] angle_deg_o,
  input logic                   angle_valid_o
);

  // A result never leaves the tilt range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (angle_deg_o <= 16'sd23040) && (angle_deg_o >= -16'sd23040))
    else $error("angle out of range");

  // A result flagged as invalid carries a zero angle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !angle_valid_o) |-> (angle_deg_o == '0))
    else $error("invalid result with nonzero angle");

  // The block is busy in the cycle after a sample transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready right after a sample transfer");

  // A stalled result holds its valid and payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(angle_deg_o) && $stable(angle_valid_o)))
    else $error("stalled result changed");

endmodule

bind tilt_angle_estimator tae_checker u_tae_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .angle_deg_o   (angle_deg_o),
  .angle_valid_o (angle_valid_o)
);
